### rtl/s5hp_pkg.sv
package s5hp_pkg;

    // result kinds
    localparam logic [2:0] KIND_REPLY   = 3'd0;
    localparam logic [2:0] KIND_NAME    = 3'd1;
    localparam logic [2:0] KIND_CONNECT = 3'd2;
    localparam logic [2:0] KIND_RESOLVE = 3'd3;
    localparam logic [2:0] KIND_CLOSE   = 3'd4;

    // protocol byte values
    localparam logic [7:0] SOCKS_VER      = 8'h05;
    localparam logic [7:0] METHOD_NOAUTH  = 8'h00;
    localparam logic [7:0] REP_OK         = 8'h00;
    localparam logic [7:0] REP_NO_METHOD  = 8'hFF;
    localparam logic [7:0] REP_CMD_UNSUP  = 8'h07;
    localparam logic [7:0] REP_ATYP_UNSUP = 8'h08;
    localparam logic [7:0] CMD_CONNECT    = 8'h01;
    localparam logic [7:0] ATYP_IPV4      = 8'h01;
    localparam logic [7:0] ATYP_DOMAIN    = 8'h03;
    localparam logic [7:0] RSV_BYTE       = 8'h00;

    // burst lengths
    localparam logic [3:0] GREET_REPLY_LEN = 4'd2;
    localparam logic [3:0] REQ_REPLY_LEN   = 4'd10;
    localparam logic [3:0] MAX_BURST       = 4'd11;

    // one burst of results caused by a single input byte
    typedef struct packed {
        logic [3:0]  count;      // total results in the burst
        logic [3:0]  reply_len;  // leading reply bytes
        logic [7:0]  reply_code; // second reply byte
        logic [2:0]  fin_kind;   // trailing item after the reply bytes
        logic [7:0]  fin_data;
        logic [31:0] fin_ipv4;
        logic [15:0] fin_port;
        logic [7:0]  fin_nlen;
    } burst_t;

endpackage

### rtl/s5hp_parser.sv
module s5hp_parser (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            in_fire,
    input  logic [7:0]      rx_byte,
    input  logic            stream_end,
    output logic            burst_valid,
    output s5hp_pkg::burst_t burst
);
    import s5hp_pkg::*;

    // parser phases
    localparam logic [3:0] PH_G_VER   = 4'd0;
    localparam logic [3:0] PH_G_NMETH = 4'd1;
    localparam logic [3:0] PH_G_METH  = 4'd2;
    localparam logic [3:0] PH_R_VER   = 4'd3;
    localparam logic [3:0] PH_R_CMD   = 4'd4;
    localparam logic [3:0] PH_R_RSV   = 4'd5;
    localparam logic [3:0] PH_R_ATYP  = 4'd6;
    localparam logic [3:0] PH_R_ADDR  = 4'd7;
    localparam logic [3:0] PH_R_DLEN  = 4'd8;
    localparam logic [3:0] PH_R_NAME  = 4'd9;
    localparam logic [3:0] PH_R_PORT  = 4'd10;
    localparam logic [3:0] PH_DONE    = 4'd11;

    logic [3:0]  phase_reg, phase_next;
    logic [8:0]  byte_count_reg, byte_count_next;
    logic [7:0]  method_count_reg, method_count_next;
    logic        no_auth_reg, no_auth_next;
    logic [7:0]  reply_code_reg, reply_code_next;
    logic [7:0]  address_kind_reg, address_kind_next;
    logic [31:0] address_reg, address_next;
    logic [15:0] port_reg, port_next;
    logic [7:0]  domain_length_reg, domain_length_next;

    logic [8:0]  count_inc;
    burst_t      b;

    assign count_inc = byte_count_reg + 9'd1;

    // next state and burst descriptor for the current byte
    always_comb
    begin
        phase_next         = phase_reg;
        byte_count_next    = byte_count_reg;
        method_count_next  = method_count_reg;
        no_auth_next       = no_auth_reg;
        reply_code_next    = reply_code_reg;
        address_kind_next  = address_kind_reg;
        address_next       = address_reg;
        port_next          = port_reg;
        domain_length_next = domain_length_reg;

        b.count      = 4'd0;
        b.reply_len  = 4'd0;
        b.reply_code = REP_OK;
        b.fin_kind   = KIND_CLOSE;
        b.fin_data   = 8'd0;
        b.fin_ipv4   = 32'd0;
        b.fin_port   = 16'd0;
        b.fin_nlen   = 8'd0;

        if (phase_reg >= PH_DONE)
        begin
            phase_next = phase_reg;
        end
        else if (stream_end)
        begin
            // client closed before the handshake finished
            b.count    = 4'd1;
            phase_next = PH_DONE;
        end
        else
        begin
            unique case (phase_reg)
                PH_G_VER:
                begin
                    if (rx_byte != SOCKS_VER)
                    begin
                        b.count    = 4'd1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_G_NMETH;
                    end
                end
                PH_G_NMETH:
                begin
                    method_count_next = rx_byte;
                    byte_count_next   = 9'd0;
                    no_auth_next      = 1'b0;
                    if (rx_byte == 8'd0)
                    begin
                        // no methods offered: 05 ff and close
                        b.count      = GREET_REPLY_LEN + 4'd1;
                        b.reply_len  = GREET_REPLY_LEN;
                        b.reply_code = REP_NO_METHOD;
                        phase_next   = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_G_METH;
                    end
                end
                PH_G_METH:
                begin
                    no_auth_next    = no_auth_reg | (rx_byte == METHOD_NOAUTH);
                    byte_count_next = count_inc;
                    if (count_inc >= {1'b0, method_count_reg})
                    begin
                        b.reply_len = GREET_REPLY_LEN;
                        if (no_auth_next)
                        begin
                            b.count         = GREET_REPLY_LEN;
                            b.reply_code    = REP_OK;
                            phase_next      = PH_R_VER;
                            byte_count_next = 9'd0;
                        end
                        else
                        begin
                            b.count      = GREET_REPLY_LEN + 4'd1;
                            b.reply_code = REP_NO_METHOD;
                            phase_next   = PH_DONE;
                        end
                    end
                end
                PH_R_VER:
                begin
                    if (rx_byte != SOCKS_VER)
                    begin
                        b.count    = 4'd1;
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_R_CMD;
                    end
                end
                PH_R_CMD:
                begin
                    reply_code_next = (rx_byte == CMD_CONNECT) ? REP_OK : REP_CMD_UNSUP;
                    phase_next      = PH_R_RSV;
                end
                PH_R_RSV:
                begin
                    phase_next = PH_R_ATYP;
                end
                PH_R_ATYP:
                begin
                    address_kind_next = rx_byte;
                    byte_count_next   = 9'd0;
                    address_next      = 32'd0;
                    port_next         = 16'd0;
                    if (rx_byte == ATYP_IPV4)
                    begin
                        phase_next = PH_R_ADDR;
                    end
                    else if (rx_byte == ATYP_DOMAIN)
                    begin
                        phase_next = PH_R_DLEN;
                    end
                    else
                    begin
                        // unknown address type: full reply then close
                        reply_code_next = REP_ATYP_UNSUP;
                        b.count         = MAX_BURST;
                        b.reply_len     = REQ_REPLY_LEN;
                        b.reply_code    = REP_ATYP_UNSUP;
                        phase_next      = PH_DONE;
                    end
                end
                PH_R_ADDR:
                begin
                    address_next    = {address_reg[23:0], rx_byte};
                    byte_count_next = count_inc;
                    if (count_inc >= 9'd4)
                    begin
                        byte_count_next = 9'd0;
                        phase_next      = PH_R_PORT;
                    end
                end
                PH_R_DLEN:
                begin
                    domain_length_next = rx_byte;
                    byte_count_next    = 9'd0;
                    phase_next         = (rx_byte == 8'd0) ? PH_R_PORT : PH_R_NAME;
                end
                PH_R_NAME:
                begin
                    // pass the name byte on as it arrives
                    b.count         = 4'd1;
                    b.fin_kind      = KIND_NAME;
                    b.fin_data      = rx_byte;
                    byte_count_next = count_inc;
                    if (count_inc >= {1'b0, domain_length_reg})
                    begin
                        byte_count_next = 9'd0;
                        phase_next      = PH_R_PORT;
                    end
                end
                PH_R_PORT:
                begin
                    port_next       = {port_reg[7:0], rx_byte};
                    byte_count_next = count_inc;
                    if (count_inc >= 9'd2)
                    begin
                        // request complete: reply then connect, resolve or close
                        byte_count_next = 9'd0;
                        phase_next      = PH_DONE;
                        b.count         = MAX_BURST;
                        b.reply_len     = REQ_REPLY_LEN;
                        b.reply_code    = reply_code_reg;
                        if (reply_code_reg != REP_OK)
                        begin
                            b.fin_kind = KIND_CLOSE;
                        end
                        else if (address_kind_reg == ATYP_IPV4)
                        begin
                            b.fin_kind = KIND_CONNECT;
                            b.fin_ipv4 = address_reg;
                            b.fin_port = port_next;
                        end
                        else
                        begin
                            b.fin_kind = KIND_RESOLVE;
                            b.fin_port = port_next;
                            b.fin_nlen = domain_length_reg;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_DONE;
                end
            endcase
        end
    end

    assign burst       = b;
    assign burst_valid = in_fire && (b.count != 4'd0);

    // parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg         <= PH_G_VER;
            byte_count_reg    <= 9'd0;
            method_count_reg  <= 8'd0;
            no_auth_reg       <= 1'b0;
            reply_code_reg    <= 8'd0;
            address_kind_reg  <= 8'd0;
            address_reg       <= 32'd0;
            port_reg          <= 16'd0;
            domain_length_reg <= 8'd0;
        end
        else if (in_fire)
        begin
            phase_reg         <= phase_next;
            byte_count_reg    <= byte_count_next;
            method_count_reg  <= method_count_next;
            no_auth_reg       <= no_auth_next;
            reply_code_reg    <= reply_code_next;
            address_kind_reg  <= address_kind_next;
            address_reg       <= address_next;
            port_reg          <= port_next;
            domain_length_reg <= domain_length_next;
        end
    end

    // once finished the parser stays finished
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == PH_DONE |=> phase_reg == PH_DONE)
        else $error("parser left the done phase");

    // phase never runs past done
    assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg <= PH_DONE)
        else $error("parser phase out of range");

    // a full reply burst only comes from the address type or port bytes
    assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid && (b.count == MAX_BURST) |->
            (phase_reg == PH_R_ATYP) || (phase_reg == PH_R_PORT))
        else $error("full reply burst from unexpected phase");

endmodule

### rtl/s5hp_emitter.sv
module s5hp_emitter (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             burst_valid,
    input  s5hp_pkg::burst_t burst,
    output logic             burst_take,
    input  logic [31:0]      bound_ipv4,
    input  logic [15:0]      bound_port,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [2:0]       kind,
    output logic [7:0]       data_byte,
    output logic [31:0]      target_ipv4,
    output logic [15:0]      target_port,
    output logic [7:0]       name_length,
    output logic             last
);
    import s5hp_pkg::*;

    logic        pend_valid_reg;
    burst_t      pend_reg;
    logic [3:0]  idx_reg;

    logic        out_valid_reg;
    logic [2:0]  kind_reg;
    logic [7:0]  data_reg;
    logic [31:0] ipv4_reg;
    logic [15:0] port_reg;
    logic [7:0]  nlen_reg;
    logic        last_reg;

    logic        out_free;
    logic        emit;
    logic        item_last;
    logic        item_reply;
    logic [7:0]  reply_byte;

    assign out_free   = !out_valid_reg || !out_stall;
    assign emit       = pend_valid_reg && out_free;
    assign item_last  = idx_reg == (pend_reg.count - 4'd1);
    assign item_reply = idx_reg < pend_reg.reply_len;
    assign burst_take = !pend_valid_reg || (emit && item_last);

    // reply byte at the current position of the ten-byte reply
    always_comb
    begin
        unique case (idx_reg)
            4'd0:    reply_byte = SOCKS_VER;
            4'd1:    reply_byte = pend_reg.reply_code;
            4'd2:    reply_byte = RSV_BYTE;
            4'd3:    reply_byte = ATYP_IPV4;
            4'd4:    reply_byte = bound_ipv4[31:24];
            4'd5:    reply_byte = bound_ipv4[23:16];
            4'd6:    reply_byte = bound_ipv4[15:8];
            4'd7:    reply_byte = bound_ipv4[7:0];
            4'd8:    reply_byte = bound_port[15:8];
            4'd9:    reply_byte = bound_port[7:0];
            default: reply_byte = 8'd0;
        endcase
    end

    // pending burst and position within it
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            idx_reg        <= 4'd0;
        end
        else if (burst_valid && burst_take)
        begin
            pend_valid_reg <= 1'b1;
            idx_reg        <= 4'd0;
        end
        else if (emit && item_last)
        begin
            pend_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            idx_reg <= idx_reg + 4'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst_valid && burst_take)
        begin
            pend_reg <= burst;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (emit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (emit)
        begin
            last_reg <= item_last;
            if (item_reply)
            begin
                kind_reg <= KIND_REPLY;
                data_reg <= reply_byte;
                ipv4_reg <= 32'd0;
                port_reg <= 16'd0;
                nlen_reg <= 8'd0;
            end
            else
            begin
                kind_reg <= pend_reg.fin_kind;
                data_reg <= pend_reg.fin_data;
                ipv4_reg <= pend_reg.fin_ipv4;
                port_reg <= pend_reg.fin_port;
                nlen_reg <= pend_reg.fin_nlen;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign data_byte   = data_reg;
    assign target_ipv4 = ipv4_reg;
    assign target_port = port_reg;
    assign name_length = nlen_reg;
    assign last        = last_reg;

    // position stays inside the pending burst
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> idx_reg < pend_reg.count)
        else $error("burst position past its length");

    // the reply bytes never outnumber the burst
    assert property (@(posedge clk) disable iff (!rst_n)
        pend_valid_reg |-> pend_reg.reply_len <= pend_reg.count)
        else $error("reply length exceeds burst length");

    // a stalled result stays put
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |=>
            out_valid_reg && $stable(kind_reg) && $stable(data_reg) && $stable(last_reg))
        else $error("stalled result changed");

endmodule

### rtl/socks5_handshake_parser_core.sv
// socks5 server handshake parser, one client byte per cycle while the input is not stalled
// first result of a byte passes through the pending burst register and then the output register
// throughput one byte per cycle while each byte gives at most one result and the output is not stalled
// a burst of several results stalls the input while the result sequencer emits it
// reset clears the parser to expect a greeting, bound address 127.0.0.1 port 0
module socks5_handshake_parser_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  rx_byte,
    input  logic        stream_end,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  kind,
    output logic [7:0]  data_byte,
    output logic [31:0] target_ipv4,
    output logic [15:0] target_port,
    output logic [7:0]  name_length,
    output logic        last,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [31:0] cfg_data
);
    import s5hp_pkg::*;

    localparam logic CFG_BOUND_IPV4 = 1'b0;
    localparam logic CFG_BOUND_PORT = 1'b1;

    logic        bound_ipv4_reg;
    logic [31:0] ipv4_cfg_reg;
    logic [15:0] port_cfg_reg;
    logic        in_fire;
    logic        burst_valid;
    logic        burst_take;
    burst_t      burst;

    assign cfg_ready = 1'b1;
    assign in_stall  = !burst_take;
    assign in_fire   = in_valid && !in_stall;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ipv4_cfg_reg <= 32'h7F00_0001;
            port_cfg_reg <= 16'd0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_BOUND_IPV4: ipv4_cfg_reg <= cfg_data;
                CFG_BOUND_PORT: port_cfg_reg <= cfg_data[15:0];
                default:        port_cfg_reg <= port_cfg_reg;
            endcase
        end
    end

    // marks that a write to the bound address index has been seen since reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bound_ipv4_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready && (cfg_index == CFG_BOUND_IPV4))
        begin
            bound_ipv4_reg <= 1'b1;
        end
    end

    s5hp_parser u_parser (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .rx_byte     (rx_byte),
        .stream_end  (stream_end),
        .burst_valid (burst_valid),
        .burst       (burst)
    );

    s5hp_emitter u_emitter (
        .clk         (clk),
        .rst_n       (rst_n),
        .burst_valid (burst_valid),
        .burst       (burst),
        .burst_take  (burst_take),
        .bound_ipv4  (ipv4_cfg_reg),
        .bound_port  (port_cfg_reg),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .data_byte   (data_byte),
        .target_ipv4 (target_ipv4),
        .target_port (target_port),
        .name_length (name_length),
        .last        (last)
    );

    // a new burst is only taken on an accepted byte
    assert property (@(posedge clk) disable iff (!rst_n)
        burst_valid |-> in_fire)
        else $error("burst without an accepted byte");

    // the address register only changes through a write to its index
    assert property (@(posedge clk) disable iff (!rst_n)
        bound_ipv4_reg == 1'b0 |-> ipv4_cfg_reg == 32'h7F00_0001)
        else $error("bound address changed without a write");

    // only defined result kinds leave the block
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> kind <= KIND_CLOSE)
        else $error("result kind out of range");

endmodule

### bench/tb.sv
module tb;
    import s5hp_pkg::*;

    // register indexes of the config port
    localparam logic REG_BOUND_IPV4 = 1'b0;
    localparam logic REG_BOUND_PORT = 1'b1;

    localparam int CYCLE_LIMIT = 200000;

    // parser phases of the expected-result model
    typedef enum logic [3:0] {
        PH_G_VER,
        PH_G_NMETH,
        PH_G_METH,
        PH_R_VER,
        PH_R_CMD,
        PH_R_RSV,
        PH_R_ATYP,
        PH_R_ADDR,
        PH_R_DLEN,
        PH_R_NAME,
        PH_R_PORT,
        PH_DONE
    } phase_t;

    // shapes of the client request sent after the greeting
    typedef enum logic [1:0] {
        SC_DOMAIN,
        SC_IPV4,
        SC_BAD_ATYP,
        SC_BAD_VER
    } request_shape_t;

    typedef struct packed {
        logic [2:0]  kind;
        logic [7:0]  data;
        logic [31:0] ipv4;
        logic [15:0] port;
        logic [7:0]  nlen;
        logic        last;
    } server_item_t;

    // one greeting byte, with the reply typed in where it is obvious
    typedef struct packed {
        logic [7:0] rx;
        logic       closed;
        logic       typed;
        logic [1:0] n_reply;
        logic [7:0] rep;
    } greet_row_t;

    localparam greet_row_t GREETING_ROWS [0:11] = '{
        '{8'h05, 1'b0, 1'b1, 2'd0, REP_OK},
        '{8'h0A, 1'b0, 1'b1, 2'd0, REP_OK},
        '{8'hFF, 1'b0, 1'b0, 2'd0, REP_OK},
        '{8'h00, 1'b0, 1'b0, 2'd0, REP_OK},
        '{8'h01, 1'b0, 1'b0, 2'd0, REP_OK},
        '{8'h80, 1'b0, 1'b0, 2'd0, REP_OK},
        '{8'h7F, 1'b0, 1'b0, 2'd0, REP_OK},
        '{8'hFE, 1'b0, 1'b0, 2'd0, REP_OK},
        '{8'h02, 1'b0, 1'b0, 2'd0, REP_OK},
        '{8'h55, 1'b0, 1'b0, 2'd0, REP_OK},
        '{8'hAA, 1'b0, 1'b0, 2'd0, REP_OK},
        '{8'h03, 1'b0, 1'b1, 2'd2, REP_OK}
    };

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        in_valid = 1'b0;
    logic        in_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        stream_end = 1'b0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    logic [2:0]  kind;
    logic [7:0]  data_byte;
    logic [31:0] target_ipv4;
    logic [15:0] target_port;
    logic [7:0]  name_length;
    logic        last;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic        cfg_index = 1'b0;
    logic [31:0] cfg_data = 32'h0;

    // model state
    phase_t      st_phase;
    logic [8:0]  st_count;
    logic [7:0]  st_methods;
    logic        st_noauth;
    logic [7:0]  st_rep;
    logic [7:0]  st_atyp;
    logic [31:0] st_addr;
    logic [15:0] st_port;
    logic [7:0]  st_dlen;
    logic [31:0] bound_addr;
    logic [15:0] bound_port_val;

    server_item_t step_items[$];
    server_item_t due_server_items[$];

    int mismatches = 0;
    int results_seen = 0;
    int sent_count = 0;
    int cycle_count = 0;

    socks5_handshake_parser_core uut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .rx_byte    (rx_byte),
        .stream_end (stream_end),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .data_byte  (data_byte),
        .target_ipv4(target_ipv4),
        .target_port(target_port),
        .name_length(name_length),
        .last       (last),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data)
    );

    always #1 clk = ~clk;

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("tb: FAIL");
            $finish;
        end
    end

    // append one result to the queue of results still to come
    function automatic void queue_expected(input server_item_t it);
        due_server_items.insert(due_server_items.size(), it);
    endfunction

    function automatic void add_item(input logic [2:0] k, input logic [7:0] d,
                                     input logic [31:0] ip, input logic [15:0] p,
                                     input logic [7:0] n);
        server_item_t it;
        it.kind = k;
        it.data = d;
        it.ipv4 = ip;
        it.port = p;
        it.nlen = n;
        it.last = 1'b0;
        step_items.insert(step_items.size(), it);
    endfunction

    // ten-byte request reply with the bound address
    function automatic void add_request_reply();
        add_item(KIND_REPLY, SOCKS_VER, 32'h0, 16'h0, 8'h0);
        add_item(KIND_REPLY, st_rep, 32'h0, 16'h0, 8'h0);
        add_item(KIND_REPLY, RSV_BYTE, 32'h0, 16'h0, 8'h0);
        add_item(KIND_REPLY, ATYP_IPV4, 32'h0, 16'h0, 8'h0);
        add_item(KIND_REPLY, bound_addr[31:24], 32'h0, 16'h0, 8'h0);
        add_item(KIND_REPLY, bound_addr[23:16], 32'h0, 16'h0, 8'h0);
        add_item(KIND_REPLY, bound_addr[15:8], 32'h0, 16'h0, 8'h0);
        add_item(KIND_REPLY, bound_addr[7:0], 32'h0, 16'h0, 8'h0);
        add_item(KIND_REPLY, bound_port_val[15:8], 32'h0, 16'h0, 8'h0);
        add_item(KIND_REPLY, bound_port_val[7:0], 32'h0, 16'h0, 8'h0);
    endfunction

    function automatic void give_up();
        st_phase = PH_DONE;
        add_item(KIND_CLOSE, 8'h0, 32'h0, 16'h0, 8'h0);
    endfunction

    // results the server gives for one client byte
    function automatic void parse_client_byte(input logic [7:0] b, input logic closed);
        step_items.delete();
        if (st_phase == PH_DONE)
            return;
        if (closed)
            give_up();
        else
        begin
            case (st_phase)
                PH_G_VER:
                    if (b != SOCKS_VER)
                        give_up();
                    else
                        st_phase = PH_G_NMETH;
                PH_G_NMETH:
                begin
                    st_methods = b;
                    st_count = 9'd0;
                    st_noauth = 1'b0;
                    if (b == 8'd0)
                    begin
                        add_item(KIND_REPLY, SOCKS_VER, 32'h0, 16'h0, 8'h0);
                        add_item(KIND_REPLY, REP_NO_METHOD, 32'h0, 16'h0, 8'h0);
                        give_up();
                    end
                    else
                        st_phase = PH_G_METH;
                end
                PH_G_METH:
                begin
                    if (b == METHOD_NOAUTH)
                        st_noauth = 1'b1;
                    st_count = st_count + 9'd1;
                    if (st_count >= {1'b0, st_methods})
                    begin
                        add_item(KIND_REPLY, SOCKS_VER, 32'h0, 16'h0, 8'h0);
                        if (st_noauth)
                        begin
                            add_item(KIND_REPLY, REP_OK, 32'h0, 16'h0, 8'h0);
                            st_phase = PH_R_VER;
                            st_count = 9'd0;
                        end
                        else
                        begin
                            add_item(KIND_REPLY, REP_NO_METHOD, 32'h0, 16'h0, 8'h0);
                            give_up();
                        end
                    end
                end
                PH_R_VER:
                    if (b != SOCKS_VER)
                        give_up();
                    else
                        st_phase = PH_R_CMD;
                PH_R_CMD:
                begin
                    st_rep = (b == CMD_CONNECT) ? REP_OK : REP_CMD_UNSUP;
                    st_phase = PH_R_RSV;
                end
                PH_R_RSV:
                    st_phase = PH_R_ATYP;
                PH_R_ATYP:
                begin
                    st_atyp = b;
                    st_count = 9'd0;
                    st_addr = 32'h0;
                    st_port = 16'h0;
                    if (b == ATYP_IPV4)
                        st_phase = PH_R_ADDR;
                    else if (b == ATYP_DOMAIN)
                        st_phase = PH_R_DLEN;
                    else
                    begin
                        st_rep = REP_ATYP_UNSUP;
                        add_request_reply();
                        give_up();
                    end
                end
                PH_R_ADDR:
                begin
                    st_addr = {st_addr[23:0], b};
                    st_count = st_count + 9'd1;
                    if (st_count >= 9'd4)
                    begin
                        st_count = 9'd0;
                        st_phase = PH_R_PORT;
                    end
                end
                PH_R_DLEN:
                begin
                    st_dlen = b;
                    st_count = 9'd0;
                    st_phase = (b == 8'd0) ? PH_R_PORT : PH_R_NAME;
                end
                PH_R_NAME:
                begin
                    add_item(KIND_NAME, b, 32'h0, 16'h0, 8'h0);
                    st_count = st_count + 9'd1;
                    if (st_count >= {1'b0, st_dlen})
                    begin
                        st_count = 9'd0;
                        st_phase = PH_R_PORT;
                    end
                end
                PH_R_PORT:
                begin
                    st_port = {st_port[7:0], b};
                    st_count = st_count + 9'd1;
                    if (st_count >= 9'd2)
                    begin
                        st_count = 9'd0;
                        add_request_reply();
                        st_phase = PH_DONE;
                        if (st_rep != REP_OK)
                            add_item(KIND_CLOSE, 8'h0, 32'h0, 16'h0, 8'h0);
                        else if (st_atyp == ATYP_IPV4)
                            add_item(KIND_CONNECT, 8'h0, st_addr, st_port, 8'h0);
                        else
                            add_item(KIND_RESOLVE, 8'h0, 32'h0, st_port, st_dlen);
                    end
                end
                default:
                    st_phase = PH_DONE;
            endcase
        end
        if (step_items.size() != 0)
            step_items[step_items.size() - 1].last = 1'b1;
    endfunction

    // offer one client byte and wait until it is taken
    task automatic offer_byte(input logic [7:0] b, input logic closed);
        if ((sent_count < 40 || sent_count >= 90) && $urandom_range(99) < 6)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        rx_byte <= b;
        stream_end <= closed;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        sent_count++;
    endtask

    task automatic send_checked(input logic [8:0] cb);
        offer_byte(cb[7:0], cb[8]);
        parse_client_byte(cb[7:0], cb[8]);
        foreach (step_items[i])
            queue_expected(step_items[i]);
    endtask

    // stop sending and let every expected result drain out
    task automatic settle();
        in_valid <= 1'b0;
        while (due_server_items.size() != 0)
            @(posedge clk);
        repeat (6) @(posedge clk);
    endtask

    task automatic write_regs(input logic [31:0] addr, input logic [31:0] port_word);
        cfg_valid <= 1'b1;
        cfg_index <= REG_BOUND_IPV4;
        cfg_data <= addr;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        bound_addr = addr;
        cfg_index <= REG_BOUND_PORT;
        cfg_data <= port_word;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        bound_port_val = port_word[15:0];
        cfg_valid <= 1'b0;
    endtask

    // result checker and receiver stall control
    initial
    begin : result_side
        server_item_t got;
        server_item_t want;
        int hold_left;
        bit hold_done;
        hold_left = 0;
        hold_done = 1'b0;
        forever
        begin
            @(posedge clk);
            if (out_valid && !out_stall)
            begin
                got = '{kind, data_byte, target_ipv4, target_port, name_length, last};
                results_seen++;
                if (due_server_items.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"unexpected result: kind=%0d data=%02h ip=%08h ",
                                  "port=%04h len=%0d last=%0b"},
                                 got.kind, got.data, got.ipv4, got.port, got.nlen, got.last);
                end
                else
                begin
                    want = due_server_items.pop_front();
                    if (got.kind != want.kind || got.data != want.data ||
                        got.ipv4 != want.ipv4 || got.port != want.port ||
                        got.nlen != want.nlen || got.last != want.last)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch at result %0d: want kind=%0d data=%02h ",
                                      "ip=%08h port=%04h len=%0d last=%0b, got kind=%0d ",
                                      "data=%02h ip=%08h port=%04h len=%0d last=%0b"},
                                     results_seen, want.kind, want.data, want.ipv4, want.port,
                                     want.nlen, want.last, got.kind, got.data, got.ipv4,
                                     got.port, got.nlen, got.last);
                    end
                end
            end
            // one long hold-off, a quiet stretch, otherwise sparse random stalls
            if (hold_left != 0)
            begin
                hold_left = hold_left - 1;
                out_stall <= (hold_left != 0);
            end
            else if (!hold_done && out_valid && results_seen >= 2)
            begin
                hold_done = 1'b1;
                hold_left = 60;
                out_stall <= 1'b1;
            end
            else if (results_seen >= 20 && results_seen < 60)
                out_stall <= 1'b0;
            else
                out_stall <= ($urandom_range(99) < 6);
        end
    end

    initial
    begin : client_side
        logic [8:0] header[$];
        logic [8:0] body[$];
        request_shape_t shape;
        int pick;
        int dlen;
        int pad;
        logic [7:0] b;

        st_phase = PH_G_VER;
        st_count = 9'd0;
        st_methods = 8'd0;
        st_noauth = 1'b0;
        st_rep = 8'd0;
        st_atyp = 8'd0;
        st_addr = 32'h0;
        st_port = 16'h0;
        st_dlen = 8'd0;
        bound_addr = 32'h7F000001;
        bound_port_val = 16'h0;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // low extremes of the bound address and port
        write_regs(32'h0000_0000, 32'h0000_0000);

        // directed greeting with extreme method bytes
        foreach (GREETING_ROWS[i])
        begin
            offer_byte(GREETING_ROWS[i].rx, GREETING_ROWS[i].closed);
            parse_client_byte(GREETING_ROWS[i].rx, GREETING_ROWS[i].closed);
            if (GREETING_ROWS[i].typed)
            begin
                if (GREETING_ROWS[i].n_reply == 2'd2)
                begin
                    queue_expected('{KIND_REPLY, SOCKS_VER, 32'h0, 16'h0, 8'h0, 1'b0});
                    queue_expected('{KIND_REPLY, GREETING_ROWS[i].rep, 32'h0, 16'h0,
                                     8'h0, 1'b1});
                end
            end
            else
                foreach (step_items[j])
                    queue_expected(step_items[j]);
        end

        settle();
        write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);

        // pick the request shape
        pick = $urandom_range(99);
        if (pick < 70)
            shape = SC_DOMAIN;
        else if (pick < 88)
            shape = SC_IPV4;
        else if (pick < 95)
            shape = SC_BAD_ATYP;
        else
            shape = SC_BAD_VER;

        // request header: version, command, reserved, address type
        b = SOCKS_VER;
        if (shape == SC_BAD_VER)
        begin
            b = 8'($urandom_range(255));
            if (b == SOCKS_VER)
                b = ~SOCKS_VER;
        end
        header.insert(header.size(), {1'b0, b});
        b = ($urandom_range(3) == 0) ? 8'($urandom_range(255)) : CMD_CONNECT;
        header.insert(header.size(), {1'b0, b});
        header.insert(header.size(), {1'b0, 8'($urandom_range(255))});
        if (shape == SC_IPV4)
            b = ATYP_IPV4;
        else if (shape == SC_BAD_ATYP)
        begin
            do
                b = 8'($urandom_range(255));
            while (b == ATYP_IPV4 || b == ATYP_DOMAIN);
        end
        else
            b = ATYP_DOMAIN;
        header.insert(header.size(), {1'b0, b});
        foreach (header[i])
            send_checked(header[i]);

        // bound address for the reply: an extreme or a random value
        settle();
        pick = $urandom_range(2);
        if (pick == 0)
            write_regs(32'h0000_0000, {16'($urandom_range(16'hFFFF)), 16'h0000});
        else if (pick == 1)
            write_regs(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        else
            write_regs($urandom, $urandom);

        // request body: address or name, then port
        if (shape == SC_DOMAIN)
        begin
            pick = $urandom_range(9);
            if (pick == 0)
                dlen = 0;
            else if (pick == 1)
                dlen = 255;
            else
                dlen = $urandom_range(60, 140);
            body.insert(body.size(), {1'b0, 8'(dlen)});
            repeat (dlen + 2)
                body.insert(body.size(), {1'b0, 8'($urandom_range(255))});
        end
        else if (shape == SC_IPV4)
            repeat (6)
                body.insert(body.size(), {1'b0, 8'($urandom_range(255))});

        // client closes early now and then
        if (body.size() != 0 && $urandom_range(9) == 0)
            body[$urandom_range(body.size() - 1)] = {1'b1, 8'($urandom_range(255))};

        // bytes after the handshake, closes among them, 114 to 268 body bytes
        pad = (body.size() < 104) ? 114 - body.size() : 10;
        repeat (pad)
            body.insert(body.size(), {1'($urandom_range(1)), 8'($urandom_range(255))});

        foreach (body[i])
            send_checked(body[i]);

        in_valid <= 1'b0;
        while (due_server_items.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        if (mismatches == 0 && due_server_items.size() == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

endmodule
